>>> design/markov_chain_state_sampler_macros.svh
// ----------------------------------------------------------------------------
// markov chain state sampler assertion macros
// concurrent checks on the core clock, muted while reset is low
// ----------------------------------------------------------------------------
`ifndef MARKOV_CHAIN_STATE_SAMPLER_MACROS_SVH
`define MARKOV_CHAIN_STATE_SAMPLER_MACROS_SVH

// condition implies consequence in the same cycle
`define MCSS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition implies consequence in the next cycle
`define MCSS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/mcss_pkg.sv
// ----------------------------------------------------------------------------
// mcss_pkg
// shared constants, command and error codes, sequencer states
// ----------------------------------------------------------------------------
package mcss_pkg;

	localparam int MAX_STATES_DEF     = 8;
	localparam int PROB_FRAC_BITS_DEF = 16;

	localparam int CMD_W   = 2;
	localparam int FIELD_W = 3;
	localparam int PROB_W  = 17;
	localparam int DRAW_W  = 16;
	localparam int NUM_W   = 4;
	localparam int ERR_W   = 2;
	localparam int NUM_RST = 8;

	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE = 2'd0,
		CMD_SET   = 2'd1,
		CMD_STEP  = 2'd2
	} cmd_t;

	typedef enum logic [ERR_W-1:0] {
		ERR_OK    = 2'd0,
		ERR_INDEX = 2'd1,
		ERR_SUM   = 2'd2
	} err_t;

	typedef enum logic [2:0] {
		FSM_CLEAR,
		FSM_IDLE,
		FSM_EXEC,
		FSM_SCAN,
		FSM_FINISH
	} fsm_t;

endpackage

>>> design/mcss_table.sv
// ----------------------------------------------------------------------------
// mcss_table
// transition table storage, one write and one registered read port
// ----------------------------------------------------------------------------
module mcss_table #(
	parameter int DEPTH  = 64,
	parameter int ADDR_W = 6,
	parameter int DATA_W = 17
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> design/markov_chain_state_sampler.sv
// ----------------------------------------------------------------------------
// markov_chain_state_sampler
// discrete markov chain stepping by inverse cdf over a fixed point table
// ----------------------------------------------------------------------------
// One item is taken at a time. Write, set and unused commands, and a transition
// from a state no longer in use, present their result from the EXEC state, and
// a transition presents it from the FINISH state after a row scan, in both cases
// once the output register is free. The scan is paced by the single read port
// of the table, which streams the current row one entry a cycle while the row
// sum and the running-sum pick are formed in one pass. The next item is taken
// from the cycle after the result is presented. A result waiting in the output
// register does not stop the next item from being taken, only from completing.
// After reset a pass over all MAX_STATES*MAX_STATES table entries fills them
// with 1.0, and no item is taken during it. The user must write the num_states
// register only while no item is in flight; the block itself does not enforce it.
module markov_chain_state_sampler #(
	parameter int MAX_STATES     = mcss_pkg::MAX_STATES_DEF,
	parameter int PROB_FRAC_BITS = mcss_pkg::PROB_FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [mcss_pkg::NUM_W-1:0]  cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [mcss_pkg::CMD_W-1:0]  cmd,
	input  logic [mcss_pkg::FIELD_W-1:0] state_index,
	input  logic [mcss_pkg::FIELD_W-1:0] to_state,
	input  logic [mcss_pkg::PROB_W-1:0] probability,
	input  logic [mcss_pkg::DRAW_W-1:0] random_draw,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [mcss_pkg::FIELD_W-1:0] result_state,
	output logic [mcss_pkg::ERR_W-1:0]  error_code
);

	`include "markov_chain_state_sampler_macros.svh"

	localparam int DEPTH   = MAX_STATES * MAX_STATES;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int IDX_W   = $clog2(MAX_STATES);
	localparam int COL_W   = $clog2(MAX_STATES + 1);
	localparam int ENTRY_W = (PROB_FRAC_BITS + 1 > mcss_pkg::PROB_W) ?
		PROB_FRAC_BITS + 1 : mcss_pkg::PROB_W;
	localparam int SUM_A   = ENTRY_W + $clog2(MAX_STATES) + 1;
	localparam int ACC_W   = (SUM_A > PROB_FRAC_BITS + 2) ? SUM_A : PROB_FRAC_BITS + 2;
	localparam int SHL     = (PROB_FRAC_BITS >= mcss_pkg::DRAW_W) ?
		PROB_FRAC_BITS - mcss_pkg::DRAW_W : 0;
	localparam int SHR     = (PROB_FRAC_BITS < mcss_pkg::DRAW_W) ?
		mcss_pkg::DRAW_W - PROB_FRAC_BITS : 0;
	localparam int NUM_RST = (mcss_pkg::NUM_RST > MAX_STATES) ? MAX_STATES : mcss_pkg::NUM_RST;

	localparam logic [ACC_W-1:0]   ONE_ACC   = ACC_W'(1) << PROB_FRAC_BITS;
	localparam logic [ENTRY_W-1:0] ONE_ENTRY = ENTRY_W'(1) << PROB_FRAC_BITS;

	mcss_pkg::fsm_t fsm_q, fsm_d;

	logic [ADDR_W-1:0]              clr_q;
	logic [mcss_pkg::NUM_W-1:0]     num_q;
	logic [IDX_W-1:0]               cur_q;
	logic [mcss_pkg::CMD_W-1:0]     cmd_q;
	logic [mcss_pkg::FIELD_W-1:0]   state_index_q;
	logic [mcss_pkg::FIELD_W-1:0]   to_state_q;
	logic [mcss_pkg::PROB_W-1:0]    probability_q;
	logic [mcss_pkg::DRAW_W-1:0]    random_draw_q;
	logic [COL_W-1:0]               rd_col_q;
	logic                           rd_vld_s1;
	logic [IDX_W-1:0]               rd_col_s1;
	logic [ACC_W-1:0]               acc_q;
	logic                           found_q;
	logic [IDX_W-1:0]               pick_q;
	logic                           out_valid_q;
	logic [mcss_pkg::FIELD_W-1:0]   result_state_q;
	logic [mcss_pkg::ERR_W-1:0]     error_code_q;

	logic                           out_free;
	logic                           from_bad;
	logic                           to_bad;
	logic                           cur_bad;
	logic                           step_start;
	logic [IDX_W-1:0]               last_idx;
	logic [ACC_W-1:0]               target;
	logic [ACC_W-1:0]               acc_next;
	logic [ENTRY_W-1:0]             rdata;
	logic                           mem_we;
	logic [ADDR_W-1:0]              mem_waddr;
	logic [ENTRY_W-1:0]             mem_wdata;
	logic                           mem_re;
	logic [ADDR_W-1:0]              mem_raddr;
	logic                           commit;
	mcss_pkg::err_t                 res_err;
	logic [IDX_W-1:0]               nxt_cur;
	logic [mcss_pkg::NUM_W-1:0]     cfg_clamped;

	assign cfg_ready = 1'b1;
	assign in_ready  = (fsm_q == mcss_pkg::FSM_IDLE);
	assign out_valid    = out_valid_q;
	assign result_state = result_state_q;
	assign error_code   = error_code_q;

	assign out_free   = !out_valid_q || out_ready;
	assign from_bad   = {1'b0, state_index_q} >= num_q;
	assign to_bad     = {1'b0, to_state_q} >= num_q;
	assign cur_bad    = 32'(cur_q) >= 32'(num_q);
	assign step_start = (mcss_pkg::cmd_t'(cmd_q) == mcss_pkg::CMD_STEP) && !cur_bad;
	assign last_idx   = IDX_W'(num_q - mcss_pkg::NUM_W'(1));
	assign target     = (ACC_W'(random_draw_q) << SHL) >> SHR;
	assign acc_next   = acc_q + ACC_W'(rdata);

	always_comb begin
		if (cfg_data == '0) begin
			cfg_clamped = mcss_pkg::NUM_W'(1);
		end else if (32'(cfg_data) > 32'(MAX_STATES)) begin
			cfg_clamped = mcss_pkg::NUM_W'(MAX_STATES);
		end else begin
			cfg_clamped = cfg_data;
		end
	end

	// next state
	always_comb begin
		fsm_d = fsm_q;
		case (fsm_q)
			mcss_pkg::FSM_CLEAR: begin
				if (clr_q == ADDR_W'(DEPTH - 1)) begin
					fsm_d = mcss_pkg::FSM_IDLE;
				end
			end
			mcss_pkg::FSM_IDLE: begin
				if (in_valid) begin
					fsm_d = mcss_pkg::FSM_EXEC;
				end
			end
			mcss_pkg::FSM_EXEC: begin
				if (step_start) begin
					fsm_d = mcss_pkg::FSM_SCAN;
				end else if (out_free) begin
					fsm_d = mcss_pkg::FSM_IDLE;
				end
			end
			mcss_pkg::FSM_SCAN: begin
				if (rd_vld_s1 && rd_col_s1 == last_idx) begin
					fsm_d = mcss_pkg::FSM_FINISH;
				end
			end
			mcss_pkg::FSM_FINISH: begin
				if (out_free) begin
					fsm_d = mcss_pkg::FSM_IDLE;
				end
			end
			default: fsm_d = mcss_pkg::FSM_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = ONE_ENTRY;
		mem_re    = 1'b0;
		mem_raddr = ADDR_W'(32'(cur_q) * MAX_STATES + 32'(rd_col_q));
		commit    = 1'b0;
		res_err   = mcss_pkg::ERR_OK;
		nxt_cur   = cur_q;
		case (fsm_q)
			mcss_pkg::FSM_CLEAR: begin
				mem_we = 1'b1;
			end
			mcss_pkg::FSM_EXEC: begin
				case (mcss_pkg::cmd_t'(cmd_q))
					mcss_pkg::CMD_WRITE: begin
						commit = out_free;
						if (from_bad || to_bad) begin
							res_err = mcss_pkg::ERR_INDEX;
						end else begin
							mem_we    = out_free;
							mem_waddr = ADDR_W'(32'(state_index_q) * MAX_STATES
								+ 32'(to_state_q));
							mem_wdata = ENTRY_W'(probability_q);
						end
					end
					mcss_pkg::CMD_SET: begin
						commit = out_free;
						if (from_bad) begin
							res_err = mcss_pkg::ERR_INDEX;
						end else begin
							nxt_cur = IDX_W'(state_index_q);
						end
					end
					mcss_pkg::CMD_STEP: begin
						if (cur_bad) begin
							commit  = out_free;
							res_err = mcss_pkg::ERR_INDEX;
						end
					end
					default: begin
						commit = out_free;
					end
				endcase
			end
			mcss_pkg::FSM_SCAN: begin
				mem_re = 32'(rd_col_q) < 32'(num_q);
			end
			mcss_pkg::FSM_FINISH: begin
				commit = out_free;
				if (acc_q != ONE_ACC) begin
					res_err = mcss_pkg::ERR_SUM;
				end else begin
					nxt_cur = found_q ? pick_q : last_idx;
				end
			end
			default: begin
				commit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q       <= mcss_pkg::FSM_CLEAR;
			clr_q       <= '0;
			num_q       <= mcss_pkg::NUM_W'(NUM_RST);
			cur_q       <= '0;
			rd_col_q    <= '0;
			rd_vld_s1   <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			fsm_q <= fsm_d;
			if (fsm_q == mcss_pkg::FSM_CLEAR) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			if (cfg_valid && cfg_ready) begin
				num_q <= cfg_clamped;
			end
			if (commit) begin
				cur_q <= nxt_cur;
			end
			if (fsm_q == mcss_pkg::FSM_EXEC) begin
				rd_col_q  <= '0;
				rd_vld_s1 <= 1'b0;
				found_q   <= 1'b0;
			end else begin
				rd_vld_s1 <= mem_re;
				if (mem_re) begin
					rd_col_q <= rd_col_q + COL_W'(1);
				end
				if (rd_vld_s1 && !found_q && target <= acc_next) begin
					found_q <= 1'b1;
				end
			end
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q         <= cmd;
			state_index_q <= state_index;
			to_state_q    <= to_state;
			probability_q <= probability;
			random_draw_q <= random_draw;
		end
		rd_col_s1 <= IDX_W'(rd_col_q);
		if (fsm_q == mcss_pkg::FSM_EXEC) begin
			acc_q <= '0;
		end else if (rd_vld_s1) begin
			acc_q <= acc_next;
			if (!found_q && target <= acc_next) begin
				pick_q <= rd_col_s1;
			end
		end
		if (commit) begin
			result_state_q <= mcss_pkg::FIELD_W'(nxt_cur);
			error_code_q   <= res_err;
		end
	end

	mcss_table #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W),
		.DATA_W (ENTRY_W)
	) u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (rdata)
	);

	`MCSS_ASSERT_NEXT(a_commit_result, commit, out_valid_q && result_state == mcss_pkg::FIELD_W'($past(nxt_cur)), "result register does not hold committed state")
	`MCSS_ASSERT_SAME(a_no_write_in_scan, fsm_q == mcss_pkg::FSM_SCAN, !mem_we, "table written during row scan")
	`MCSS_ASSERT_NEXT(a_accept_exec, in_valid && in_ready, fsm_q == mcss_pkg::FSM_EXEC, "accepted transfer not executed")
	`MCSS_ASSERT_SAME(a_read_only_scan, mem_re, fsm_q == mcss_pkg::FSM_SCAN, "table read outside row scan")

endmodule
